### hdl/rgb555_palette_lookup_defines.svh
// Assertion macros shared by the palette lookup checker.
`ifndef RGB555_PALETTE_LOOKUP_DEFINES_SVH
`define RGB555_PALETTE_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rgb555 palette lookup: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rgb555 palette lookup: check failed");

`endif

### hdl/rpl_pkg.sv
// Shared types, constants and functions of the RGB555 palette lookup.
`timescale 1ns / 1ps
`default_nettype none

package rpl_pkg;

	localparam int ENTRY_COUNT = 32;
	localparam int IDX_W       = $clog2(ENTRY_COUNT);
	localparam int CHAN_W      = 8;
	localparam int CMD_W       = 32;
	localparam int DOT_W       = 16;
	localparam int COORD_W     = 9;

	// Transaction kinds carried on opcode
	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_PIXEL   = 1'b1;

	// Control codes that load the fixed-table enable
	localparam logic [7:0] CODE_CTRL_A = 8'hc0;
	localparam logic [7:0] CODE_CTRL_B = 8'hc2;
	localparam int         FIXED_BIT   = 25;

	// Table update kinds, code bits 6..5
	typedef enum logic [1:0] {
		UPD_ALL   = 2'd0,
		UPD_BLUE  = 2'd1,
		UPD_GREEN = 2'd2,
		UPD_RED   = 2'd3
	} upd_t;

	// Table write request toward the three channel memories
	typedef struct packed {
		logic              we_r;
		logic              we_g;
		logic              we_b;
		logic [IDX_W-1:0]  idx;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} wr_cmd_t;

	// Pixel lookup request toward the read side
	typedef struct packed {
		logic               vld;
		logic               use_fixed;
		logic [IDX_W-1:0]   ri;
		logic [IDX_W-1:0]   gi;
		logic [IDX_W-1:0]   bi;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] line;
	} pix_req_t;

	// Fixed grey ramp: (i << 3) | (i >> 2)
	function automatic logic [CHAN_W-1:0] grey_ramp(input logic [IDX_W-1:0] i);
		grey_ramp = {i, i[IDX_W-1:IDX_W-3]};
	endfunction

endpackage

`default_nettype wire

### hdl/rpl_chan_ram.sv
// One 32 x 8 colour channel memory with per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rpl_chan_ram (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      we,
	input  wire logic [rpl_pkg::IDX_W-1:0] waddr,
	input  wire logic [rpl_pkg::CHAN_W-1:0] wdata,
	input  wire logic [rpl_pkg::IDX_W-1:0] raddr,
	output logic      [rpl_pkg::CHAN_W-1:0] rdata
);

	logic [rpl_pkg::CHAN_W-1:0]      mem [rpl_pkg::ENTRY_COUNT];
	logic [rpl_pkg::ENTRY_COUNT-1:0] valid_q;
	logic [rpl_pkg::CHAN_W-1:0]      rdata_q;
	logic                            rvalid_q;

	// Storage write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

### hdl/rpl_ctrl.sv
// Input register, command decode and fixed-table enable.
`timescale 1ns / 1ps
`default_nettype none

module rpl_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic                        opcode,
	input  wire logic [rpl_pkg::CMD_W-1:0]   command_word,
	input  wire logic [rpl_pkg::DOT_W-1:0]   dot,
	input  wire logic [rpl_pkg::COORD_W-1:0] column,
	input  wire logic [rpl_pkg::COORD_W-1:0] line,
	output rpl_pkg::wr_cmd_t                 wr,
	output rpl_pkg::pix_req_t                pix
);

	logic                        vld_s1;
	logic                        opcode_s1;
	logic [rpl_pkg::CMD_W-1:0]   cmd_s1;
	logic [rpl_pkg::DOT_W-1:0]   dot_s1;
	logic [rpl_pkg::COORD_W-1:0] column_s1;
	logic [rpl_pkg::COORD_W-1:0] line_s1;
	logic                        fixed_enable_q;

	logic [7:0]    code;
	rpl_pkg::upd_t upd;
	logic          is_cmd;
	logic          is_tbl;
	logic          is_ctrl;

	// Input register: control bit and command word reset, rest of payload not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cmd_s1 <= '0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				cmd_s1 <= command_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			dot_s1    <= dot;
			column_s1 <= column;
			line_s1   <= line;
		end
	end

	// Command decode
	assign code    = cmd_s1[31:24];
	assign upd     = rpl_pkg::upd_t'(code[6:5]);
	assign is_cmd  = vld_s1 && (opcode_s1 == rpl_pkg::OP_COMMAND);
	assign is_tbl  = is_cmd && !code[7];
	assign is_ctrl = is_cmd && (code == rpl_pkg::CODE_CTRL_A || code == rpl_pkg::CODE_CTRL_B);

	always_comb begin
		wr.we_r = 1'b0;
		wr.we_g = 1'b0;
		wr.we_b = 1'b0;
		unique case (upd)
			rpl_pkg::UPD_ALL: begin
				wr.we_r = is_tbl;
				wr.we_g = is_tbl;
				wr.we_b = is_tbl;
			end
			rpl_pkg::UPD_BLUE:  wr.we_b = is_tbl;
			rpl_pkg::UPD_GREEN: wr.we_g = is_tbl;
			rpl_pkg::UPD_RED:   wr.we_r = is_tbl;
		endcase
		wr.idx = code[rpl_pkg::IDX_W-1:0];
		wr.r   = cmd_s1[23:16];
		wr.g   = cmd_s1[15:8];
		wr.b   = cmd_s1[7:0];
	end

	// Fixed-table enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_enable_q <= 1'b0;
		end else if (is_ctrl) begin
			fixed_enable_q <= cmd_s1[rpl_pkg::FIXED_BIT];
		end
	end

	// Pixel request: indices go to the memories this cycle
	assign pix.vld       = vld_s1 && (opcode_s1 == rpl_pkg::OP_PIXEL);
	assign pix.use_fixed = fixed_enable_q && dot_s1[15];
	assign pix.ri        = dot_s1[14:10];
	assign pix.gi        = dot_s1[9:5];
	assign pix.bi        = dot_s1[4:0];
	assign pix.column    = column_s1;
	assign pix.line      = line_s1;

endmodule

`default_nettype wire

### hdl/rpl_out_stage.sv
// Result register and fixed-ramp / table select.
`timescale 1ns / 1ps
`default_nettype none

module rpl_out_stage (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rpl_pkg::pix_req_t            pix,
	input  wire logic [rpl_pkg::CHAN_W-1:0]   tbl_r,
	input  wire logic [rpl_pkg::CHAN_W-1:0]   tbl_g,
	input  wire logic [rpl_pkg::CHAN_W-1:0]   tbl_b,
	output logic                              done,
	output logic      [rpl_pkg::CHAN_W-1:0]   red,
	output logic      [rpl_pkg::CHAN_W-1:0]   green,
	output logic      [rpl_pkg::CHAN_W-1:0]   blue,
	output logic      [rpl_pkg::COORD_W-1:0]  out_column,
	output logic      [rpl_pkg::COORD_W-1:0]  out_line
);

	logic                        done_s2;
	logic                        use_fixed_s2;
	logic [rpl_pkg::CHAN_W-1:0]  ramp_r_s2;
	logic [rpl_pkg::CHAN_W-1:0]  ramp_g_s2;
	logic [rpl_pkg::CHAN_W-1:0]  ramp_b_s2;
	logic [rpl_pkg::COORD_W-1:0] column_s2;
	logic [rpl_pkg::COORD_W-1:0] line_s2;

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= pix.vld;
		end
	end

	// Payload alongside the memory read
	always_ff @(posedge clk) begin
		use_fixed_s2 <= pix.use_fixed;
		ramp_r_s2    <= rpl_pkg::grey_ramp(pix.ri);
		ramp_g_s2    <= rpl_pkg::grey_ramp(pix.gi);
		ramp_b_s2    <= rpl_pkg::grey_ramp(pix.bi);
		column_s2    <= pix.column;
		line_s2      <= pix.line;
	end

	assign done       = done_s2;
	assign red        = use_fixed_s2 ? ramp_r_s2 : tbl_r;
	assign green      = use_fixed_s2 ? ramp_g_s2 : tbl_g;
	assign blue       = use_fixed_s2 ? ramp_b_s2 : tbl_b;
	assign out_column = column_s2;
	assign out_line   = line_s2;

endmodule

`default_nettype wire

### hdl/rgb555_palette_lookup.sv
// Top level of the RGB555 palette lookup.
//
// One input channel: a transaction is taken at a rising edge with start high
// and busy low. busy is always low, so a transaction may be started on every
// clock. opcode 0 carries a command word that rewrites a colour table entry
// (all channels or one) or loads the fixed grey ramp enable; it gives no
// result. opcode 1 carries an RGB555 dot plus its column and line.
// Each pixel transaction returns one result, registered at the input and at the memory read:
// red, green, blue, out_column and out_line are valid for exactly one cycle
// while done is high. Throughput is one transaction per clock, set by the
// single read port of each channel memory, one read per pixel.
// A command followed directly by a pixel is seen by that pixel.
// There is no stall path: the receiver must take each result as it comes.
// Reset clears the fixed enable and the valid bits of all table entries, so
// every entry reads as zero until written; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rgb555_palette_lookup (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        opcode,
	input  wire logic [rpl_pkg::CMD_W-1:0]   command_word,
	input  wire logic [rpl_pkg::DOT_W-1:0]   dot,
	input  wire logic [rpl_pkg::COORD_W-1:0] column,
	input  wire logic [rpl_pkg::COORD_W-1:0] line,
	output logic                             done,
	output logic      [rpl_pkg::CHAN_W-1:0]  red,
	output logic      [rpl_pkg::CHAN_W-1:0]  green,
	output logic      [rpl_pkg::CHAN_W-1:0]  blue,
	output logic      [rpl_pkg::COORD_W-1:0] out_column,
	output logic      [rpl_pkg::COORD_W-1:0] out_line
);

	rpl_pkg::wr_cmd_t           wr;
	rpl_pkg::pix_req_t          pix;
	logic [rpl_pkg::CHAN_W-1:0] tbl_r;
	logic [rpl_pkg::CHAN_W-1:0] tbl_g;
	logic [rpl_pkg::CHAN_W-1:0] tbl_b;
	logic                       accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Input register and command decode
	rpl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.opcode       (opcode),
		.command_word (command_word),
		.dot          (dot),
		.column       (column),
		.line         (line),
		.wr           (wr),
		.pix          (pix)
	);

	// One memory per channel, each read at its own dot field
	rpl_chan_ram u_ram_r (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr.we_r),
		.waddr  (wr.idx),
		.wdata  (wr.r),
		.raddr  (pix.ri),
		.rdata  (tbl_r)
	);

	rpl_chan_ram u_ram_g (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr.we_g),
		.waddr  (wr.idx),
		.wdata  (wr.g),
		.raddr  (pix.gi),
		.rdata  (tbl_g)
	);

	rpl_chan_ram u_ram_b (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr.we_b),
		.waddr  (wr.idx),
		.wdata  (wr.b),
		.raddr  (pix.bi),
		.rdata  (tbl_b)
	);

	// Result register and channel select
	rpl_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.tbl_r      (tbl_r),
		.tbl_g      (tbl_g),
		.tbl_b      (tbl_b),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_column (out_column),
		.out_line   (out_line)
	);

endmodule

`default_nettype wire

### hdl/rpl_checker.sv
// Port-level checks of the palette lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb555_palette_lookup_defines.svh"

module rpl_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        opcode,
	input wire logic [rpl_pkg::COORD_W-1:0] column,
	input wire logic [rpl_pkg::COORD_W-1:0] line,
	input wire logic                        done,
	input wire logic [rpl_pkg::COORD_W-1:0] out_column,
	input wire logic [rpl_pkg::COORD_W-1:0] out_line
);

	// A result only follows an accepted pixel transaction
	`RPL_ASSERT_IMPL(a_done_has_pixel, clk, arst_n, done, $past(start && !busy && opcode == rpl_pkg::OP_PIXEL, 2))

	// Every pixel transaction yields its result
	`RPL_ASSERT_NEXT(a_pixel_gives_done, clk, arst_n, start && !busy && opcode == rpl_pkg::OP_PIXEL, ##1 done)

	// Command transactions yield no result
	`RPL_ASSERT_NEXT(a_cmd_no_done, clk, arst_n, start && !busy && opcode == rpl_pkg::OP_COMMAND, ##1 !done)

	// Coordinates come back with the pixel they belong to
	`RPL_ASSERT_IMPL(a_coord_pass, clk, arst_n, done, out_column == $past(column, 2) && out_line == $past(line, 2))

endmodule

bind rgb555_palette_lookup rpl_checker u_rpl_checker (.*);

`default_nettype wire
